### sv/chd_pkg.sv
// shared types and result codes for the chunked body decoder
`default_nettype none

package chd_pkg;

    localparam int POS_W  = 48;
    localparam int BYTE_W = 8;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END      = 2'd1,
        KIND_OVERFLOW = 2'd2
    } out_kind_t;

    typedef struct packed {
        out_kind_t               kind;
        logic [BYTE_W-1:0]       payload_byte;
        logic [POS_W-1:0]        byte_position;
    } result_t;

endpackage

`default_nettype wire

### sv/chd_out_skid.sv
// result register with a skid stage between decoder and output channel
`default_nettype none

module chd_out_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire chd_pkg::result_t  in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output chd_pkg::result_t       out_data
);
    import chd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_ready || !out_valid_reg) begin
                // output free: refill from skid first, else from the new word
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg  <= in_valid;
                end
            end else if (in_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

### sv/http_chunked_body_decoder_core.sv
// Chunked HTTP body decoder: takes one body byte per word on the input stream, parses each
// chunk size line (whitespace, hex digits, rest ignored, ends at CR LF or after LINE_LIMIT
// bytes), passes the chunk payload bytes out with their running file position, drops the two
// bytes after each chunk and reports end of body after the zero-size chunk, or an error when a
// size exceeds 0x7FFFFFFF. A word with tuser set stops decoding silently; after a stop, end or
// error every later word is taken and ignored until reset. Each input word is handled by the
// state update logic, so one word is accepted every clock while s_axis_tready is high; the
// result goes through an output register plus skid stage, and s_axis_tready drops only while
// that skid stage holds a word that the output side has not yet taken. The configuration write
// loads the position of the first payload byte and must only happen while the block is idle.
`default_nettype none

module http_chunked_body_decoder_core #(
    parameter int LINE_LIMIT = 2048
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [chd_pkg::POS_W-1:0]  cfg_wr_data,   // start_position
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // data_byte
    input  wire logic [0:0]                 s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [55:0]                     m_axis_tdata,  // payload_byte, byte_position
    output logic [1:0]                      m_axis_tuser   // out_kind
);
    import chd_pkg::*;

    localparam int LCW = $clog2(LINE_LIMIT);

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [1:0] {
        PH_LINE, PH_PAYLOAD, PH_TRAILER, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SUB_SKIP, SUB_DIGITS, SUB_REST_DIG, SUB_REST_NODIG
    } sub_t;

    phase_t            phase_reg, phase_next;
    sub_t              sub_reg, sub_next;
    logic [31:0]       acc_reg, acc_next;
    logic [30:0]       chunk_reg, chunk_next;
    logic [LCW-1:0]    cnt_reg, cnt_next;
    logic              cr_reg, cr_next;
    logic [30:0]       rem_reg, rem_next;
    logic              trl_reg, trl_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic        accept;
    logic        res_valid;
    result_t     res;
    result_t     m_res;
    logic [7:0]  b;
    logic        is_hex;
    logic        is_ws;
    logic [3:0]  hex_val;
    logic [31:0] acc_shift;
    sub_t        sub_p, sub_e;
    logic [31:0] acc_p, acc_e;
    logic        lf_end, cnt_end, has_digits, ovf;
    logic [30:0] size_e;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign b      = s_axis_tdata;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        case (b) inside
            [8'h30:8'h39]: hex_val = b[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: hex_val = b[3:0] + 4'd9;
            default:       is_hex  = 1'b0;
        endcase
        is_ws = (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT)
             || (b == CH_FF) || (b == CH_CR);
    end

    // size line parsing of the current byte
    always_comb begin
        acc_shift = (|acc_reg[31:28]) ? 32'hFFFF_FFFF : {acc_reg[27:0], hex_val};
        sub_p = sub_reg;
        acc_p = acc_reg;
        case (sub_reg)
            SUB_SKIP: begin
                if (!is_ws) begin
                    if (!is_hex) begin
                        sub_p = SUB_REST_NODIG;
                    end else begin
                        sub_p = SUB_DIGITS;
                        acc_p = acc_shift;
                    end
                end
            end
            SUB_DIGITS: begin
                if (!is_hex) begin
                    sub_p = SUB_REST_DIG;
                end else begin
                    acc_p = acc_shift;
                end
            end
            default: ;
        endcase
        lf_end     = (cnt_reg != '0) && cr_reg && (b == CH_LF);
        cnt_end    = (cnt_reg == LCW'(LINE_LIMIT - 1));
        sub_e      = lf_end ? sub_reg : sub_p;
        acc_e      = lf_end ? acc_reg : acc_p;
        has_digits = (sub_e == SUB_DIGITS) || (sub_e == SUB_REST_DIG);
        ovf        = has_digits && acc_e[31];
        size_e     = has_digits ? acc_e[30:0] : chunk_reg;
    end

    always_comb begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        acc_next   = acc_reg;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        cr_next    = cr_reg;
        rem_next   = rem_reg;
        trl_next   = trl_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = b;
        res.byte_position = pos_reg;

        if (accept && phase_reg != PH_DONE) begin
            if (s_axis_tuser[0]) begin
                phase_next = PH_DONE;
            end else begin
                case (phase_reg)
                    PH_LINE: begin
                        if (!lf_end) begin
                            sub_next = sub_p;
                            acc_next = acc_p;
                            cr_next  = (b == CH_CR);
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (lf_end || cnt_end) begin
                            if (ovf) begin
                                phase_next        = PH_DONE;
                                res_valid         = 1'b1;
                                res.kind          = KIND_OVERFLOW;
                                res.payload_byte  = '0;
                            end else begin
                                chunk_next = size_e;
                                rem_next   = size_e;
                                trl_next   = 1'b0;
                                phase_next = (size_e != '0) ? PH_PAYLOAD : PH_TRAILER;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        res_valid = 1'b1;
                        pos_next  = pos_reg + 1'b1;
                        rem_next  = rem_reg - 1'b1;
                        if (rem_reg == 31'd1) begin
                            phase_next = PH_TRAILER;
                            trl_next   = 1'b0;
                        end
                    end
                    PH_TRAILER: begin
                        if (!trl_reg) begin
                            trl_next = 1'b1;
                        end else begin
                            trl_next = 1'b0;
                            if (chunk_reg == '0) begin
                                phase_next       = PH_DONE;
                                res_valid        = 1'b1;
                                res.kind         = KIND_END;
                                res.payload_byte = '0;
                            end else begin
                                phase_next = PH_LINE;
                                sub_next   = SUB_SKIP;
                                acc_next   = '0;
                                cnt_next   = '0;
                                cr_next    = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (cfg_wr_en) begin
            pos_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LINE;
            sub_reg   <= SUB_SKIP;
            acc_reg   <= '0;
            chunk_reg <= '0;
            cnt_reg   <= '0;
            cr_reg    <= 1'b0;
            rem_reg   <= '0;
            trl_reg   <= 1'b0;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            acc_reg   <= acc_next;
            chunk_reg <= chunk_next;
            cnt_reg   <= cnt_next;
            cr_reg    <= cr_next;
            rem_reg   <= rem_next;
            trl_reg   <= trl_next;
            pos_reg   <= pos_next;
        end
    end

    chd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_res)
    );

    assign m_axis_tdata = {m_res.byte_position, m_res.payload_byte};
    assign m_axis_tuser = m_res.kind;

    // end and error words always leave the decoder finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind != KIND_PAYLOAD) |=> (phase_reg == PH_DONE))
        else $error("end or error word without entering done");

    // once finished, only reset leaves the done phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("left done phase without reset");

    // payload words come only from the payload phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_reg == PH_PAYLOAD))
        else $error("payload word outside payload phase");

    // a chunk in progress always has bytes left
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with no bytes remaining");

    // a payload word advances the position by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_PAYLOAD && !cfg_wr_en)
            |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("position did not advance after payload word");

endmodule

`default_nettype wire

### tb/http_chunked_body_decoder_core_tb.sv
// self-checking testbench for the chunked body decoder core
`timescale 1ns / 1ps

module http_chunked_body_decoder_core_tb;

    import chd_pkg::*;

    localparam int          LINE_LIMIT   = 2048;
    localparam int          RANDOM_WORDS = 500;
    localparam int          IDLE_CYCLES  = 16;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam bit [7:0]    CHAR_CR      = 8'h0D;
    localparam bit [7:0]    CHAR_LF      = 8'h0A;

    typedef enum bit [1:0] {
        STAGE_LINE,
        STAGE_PAYLOAD,
        STAGE_TRAILER,
        STAGE_DONE
    } stage_t;

    typedef enum bit [1:0] {
        SCAN_BLANKS,
        SCAN_DIGITS,
        SCAN_REST_DIG,
        SCAN_REST_NODIG
    } scan_t;

    // tracks the decoder state and holds the output words still owed
    class chunk_decoder_scoreboard;
        bit [POS_W-1:0] base_pos;
        bit [POS_W-1:0] next_pos;
        stage_t         stage;
        scan_t          scan;
        bit [31:0]      size_acc;
        bit [30:0]      cur_size;
        bit [30:0]      remaining;
        int unsigned    line_count;
        bit             prev_cr;
        int unsigned    trailer_count;
        result_t        pending_outputs[$];
        int unsigned    errors;

        function new();
            base_pos      = '0;
            next_pos      = '0;
            stage         = STAGE_LINE;
            cur_size      = '0;
            remaining     = '0;
            trailer_count = 0;
            errors        = 0;
            open_line();
        endfunction

        function void open_line();
            scan       = SCAN_BLANKS;
            size_acc   = '0;
            line_count = 0;
            prev_cr    = 1'b0;
        endfunction

        function void set_start_position(bit [POS_W-1:0] pos);
            base_pos = pos;
            next_pos = pos;
        endfunction

        function void owe(out_kind_t kind, bit [7:0] b, bit [POS_W-1:0] pos);
            result_t r;
            r.kind          = kind;
            r.payload_byte  = b;
            r.byte_position = pos;
            pending_outputs.push_back(r);
        endfunction

        function void close_line();
            if (scan == SCAN_DIGITS || scan == SCAN_REST_DIG) begin
                if (size_acc > 32'h7FFF_FFFF) begin
                    stage = STAGE_DONE;
                    owe(KIND_OVERFLOW, 8'h00, next_pos);
                    return;
                end
                cur_size = size_acc[30:0];
            end
            remaining     = cur_size;
            trailer_count = 0;
            stage         = (remaining != 0) ? STAGE_PAYLOAD : STAGE_TRAILER;
        endfunction

        function void note_body_word(bit op, bit [7:0] b);
            int digit;
            bit blank;
            if (stage == STAGE_DONE)
                return;
            if (op) begin
                stage = STAGE_DONE;
                return;
            end
            case (stage)
                STAGE_LINE: begin
                    if (line_count != 0 && prev_cr && b == CHAR_LF) begin
                        close_line();
                        return;
                    end
                    digit = -1;
                    if (b >= "0" && b <= "9")
                        digit = b - "0";
                    else if (b >= "a" && b <= "f")
                        digit = b - "a" + 10;
                    else if (b >= "A" && b <= "F")
                        digit = b - "A" + 10;
                    blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
                    if (scan == SCAN_BLANKS && !blank)
                        scan = (digit < 0) ? SCAN_REST_NODIG : SCAN_DIGITS;
                    else if (scan == SCAN_DIGITS && digit < 0)
                        scan = SCAN_REST_DIG;
                    // accumulator saturates once another nibble would overflow it
                    if (scan == SCAN_DIGITS && digit >= 0)
                        size_acc = (size_acc > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF
                                                              : {size_acc[27:0], 4'(digit)};
                    prev_cr = (b == CHAR_CR);
                    line_count++;
                    if (line_count >= LINE_LIMIT)
                        close_line();
                end
                STAGE_PAYLOAD: begin
                    owe(KIND_PAYLOAD, b, next_pos);
                    next_pos = next_pos + 1'b1;
                    remaining--;
                    if (remaining == 0) begin
                        stage         = STAGE_TRAILER;
                        trailer_count = 0;
                    end
                end
                default: begin
                    trailer_count++;
                    if (trailer_count == 2) begin
                        trailer_count = 0;
                        if (cur_size == 0) begin
                            stage = STAGE_DONE;
                            owe(KIND_END, 8'h00, next_pos);
                        end else begin
                            stage = STAGE_LINE;
                            open_line();
                        end
                    end
                end
            endcase
        endfunction

        function void check_output_word(logic [1:0] kind, logic [55:0] data);
            result_t want;
            if (pending_outputs.size() == 0) begin
                $error("unexpected output word: out_kind %0d tdata %h", kind, data);
                errors++;
                return;
            end
            want = pending_outputs.pop_front();
            if (kind !== want.kind) begin
                $error("out_kind expected %0d actual %0d", want.kind, kind);
                errors++;
            end
            if (data[7:0] !== want.payload_byte) begin
                $error("payload_byte expected %h actual %h", want.payload_byte, data[7:0]);
                errors++;
            end
            if (data[55:8] !== want.byte_position) begin
                $error("byte_position expected %h actual %h", want.byte_position, data[55:8]);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [POS_W-1:0]   cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // data_byte
    logic [0:0]         s_axis_tuser;   // op
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [55:0]        m_axis_tdata;   // payload_byte, byte_position
    logic [1:0]         m_axis_tuser;   // out_kind

    chunk_decoder_scoreboard sb;
    int unsigned    words_sent;
    int unsigned    burst_left;
    bit             gaps_on;
    bit             hold_off_req;
    int unsigned    cycle_count;

    http_chunked_body_decoder_core #(
        .LINE_LIMIT(LINE_LIMIT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_output_word(m_axis_tuser, m_axis_tdata);
    end

    // output ready follows a rotating pattern, re-picked at the end of each randomly sized segment
    initial begin : rx_ready_gen
        bit [15:0]      pat;
        int unsigned    seg_left;
        seg_left = 0;
        pat      = '1;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 64);
                case ($urandom_range(0, 3))
                    0: pat = '1;
                    1: pat = 16'($urandom) | 16'h0001;
                    2: pat = 16'($urandom | $urandom);
                    default: pat = 16'h00FF;
                endcase
            end
            seg_left--;
            pat = {pat[14:0], pat[15]};
            m_axis_tready <= pat[0];
        end
    end

    task automatic send_word(bit op, bit [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        sb.note_body_word(op, b);
        words_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_word(1'b0, s[i]);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_start_position(bit [POS_W-1:0] pos);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pos;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_start_position(pos);
    endtask

    function automatic bit is_hex(bit [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // size line: blanks, hex size or a non-digit, extension junk, then CR LF or padding
    task automatic send_line(bit [31:0] size, bit with_digits, bit to_limit);
        bit [7:0]   text[$];
        bit [7:0]   c;
        bit [3:0]   nib;
        bit         started;
        int         i;
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0: c = 8'h20;
                1: c = 8'h09;
                2: c = CHAR_LF;
                3: c = 8'h0B;
                4: c = 8'h0C;
                default: c = CHAR_CR;
            endcase
            // a CR LF here would close the line before any digit
            if (c == CHAR_LF && text.size() != 0 && text[$] == CHAR_CR)
                c = 8'h20;
            text.push_back(c);
        end
        if (with_digits) begin
            repeat ($urandom_range(0, 2)) text.push_back("0");
            started = 1'b0;
            for (i = 7; i >= 0; i--) begin
                nib = size[i*4 +: 4];
                if (nib != 0 || i == 0)
                    started = 1'b1;
                if (started)
                    text.push_back((nib < 10) ? 8'("0") + nib
                                   : ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + nib - 10);
            end
            if ($urandom_range(0, 1) || to_limit) begin
                do c = 8'($urandom); while (is_hex(c) || c == CHAR_LF);
                text.push_back(c);
                repeat ($urandom_range(0, 4)) begin
                    do c = 8'($urandom); while (c == CHAR_LF);
                    text.push_back(c);
                end
            end
        end else if ($urandom_range(0, 1)) begin
            do c = 8'($urandom);
            while (is_hex(c) || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
            text.push_back(c);
            repeat ($urandom_range(0, 4)) begin
                do c = 8'($urandom); while (c == CHAR_LF);
                text.push_back(c);
            end
        end
        if (to_limit) begin
            while (text.size() < LINE_LIMIT) begin
                do c = 8'($urandom); while (c == CHAR_LF);
                text.push_back(c);
            end
        end else begin
            text.push_back(CHAR_CR);
            text.push_back(CHAR_LF);
        end
        foreach (text[k])
            send_word(1'b0, text[k]);
    endtask

    task automatic send_chunk(int unsigned min_size, int unsigned max_size, bit to_limit);
        bit [31:0] size;
        size = ($urandom_range(0, 3) == 0) ? $urandom_range(min_size, max_size + 14)
                                           : $urandom_range(min_size, max_size);
        send_line(size, to_limit || ($urandom_range(0, 7) != 0), to_limit);
        while (sb.stage == STAGE_PAYLOAD)
            send_word(1'b0, 8'($urandom));
        while (sb.stage == STAGE_TRAILER)
            send_word(1'b0, $urandom_range(0, 1) ? 8'($urandom)
                            : (sb.trailer_count == 0 ? CHAR_CR : CHAR_LF));
    endtask

    initial begin
        int unsigned    round;
        bit [POS_W-1:0] pos;
        sb           = new();
        words_sent   = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        cycle_count  = 0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // LF first on a line, every blank, CR before a digit, digits ended by a letter
        send_text("\012\011\013\014 \0152x\015\012");
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_text("\015\012");
        // no digits: previous size is reused
        send_text("-5\015\012");
        send_word(1'b0, 8'h5A);
        send_word(1'b0, 8'hA5);
        send_text("\015\012");

        round = 0;
        while (words_sent < RANDOM_WORDS + 22) begin
            case (round % 5)
                0: pos = '1;
                1: pos = {16'($urandom), 32'($urandom)};
                2: pos = '0;
                3: pos = {40'hFF_FFFF_FFFF, 8'($urandom)};
                default: pos = {16'($urandom), 32'($urandom)};
            endcase
            load_start_position(pos);
            gaps_on = (round % 4 != 3);
            if (round == 1) begin
                hold_off_req = 1'b1;
                repeat ($urandom_range(3, 6)) send_chunk(40, 64, 1'b0);
            end else begin
                repeat ($urandom_range(3, 8)) send_chunk(1, 6, 1'b0);
            end
            round++;
        end

        // a size line that ends on its length limit rather than on CR LF
        gaps_on = 1'b1;
        send_chunk(1, 6, 1'b1);
        send_chunk(1, 6, 1'b0);

        case ($urandom_range(0, 3))
            0: begin
                send_line(32'h0, 1'b1, 1'b0);
                send_word(1'b0, CHAR_CR);
                send_word(1'b0, CHAR_LF);
            end
            1: begin
                if ($urandom_range(0, 1))
                    send_line(32'h8000_0000 | $urandom, 1'b1, 1'b0);
                else
                    send_text("fFfFfFfFfF\015\012");
            end
            2: begin
                // largest legal size, cut short by a stop word
                send_line(32'h7FFF_FFFF, 1'b1, 1'b0);
                repeat ($urandom_range(1, 8)) send_word(1'b0, 8'($urandom));
                send_word(1'b1, 8'($urandom));
            end
            default: begin
                send_text(" \011");
                send_word(1'b1, 8'($urandom));
            end
        endcase
        // everything after the end of decoding is swallowed
        repeat (12) send_word(1'($urandom), 8'($urandom));
        drain_results();

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
